// ===== rtl/core/mwq_pkg.sv =====
package mwq_pkg;

    // Command codes carried on the input stream.
    localparam logic [1:0] OP_LOCK   = 2'd0;
    localparam logic [1:0] OP_UNLOCK = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_REINIT = 2'd3;

    // Status codes returned with each result word.
    localparam logic [2:0] STAT_GRANTED  = 3'd0;
    localparam logic [2:0] STAT_QUEUED   = 3'd1;
    localparam logic [2:0] STAT_FULL     = 3'd2;
    localparam logic [2:0] STAT_DONE     = 3'd3;
    localparam logic [2:0] STAT_NOTFOUND = 3'd4;

    // Field widths fixed by the interface.
    localparam int unsigned PID_W    = 4;
    localparam int unsigned STATUS_W = 3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_WAKE,
        ST_CSCAN,
        ST_CCMP
    } state_t;

endpackage

// ===== rtl/core/mwq_ram.sv =====
module mwq_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mutex_with_fifo_wait_queue.sv =====
// Channel   Direction  Signals                      Word contents (lowest bit first)
// s_*       in         s_tvalid s_tready s_tdata     s_tdata: process_id[3:0], zero pad
//                      s_tuser                       s_tuser: operation[1:0]
// m_*       out        m_tvalid m_tready m_tdata     m_tdata: status[2:0], wake_id[6:3], pad
//                      m_tuser                       m_tuser: wake_valid
//
// Lock and reinitialize finish in the idle state. Unlock walks past cancelled slots in the
// skip state, then pops a waiter in the wake state when one is found. Cancel steps the
// slot index from slot 0 up to a match or the last slot, and each valid slot adds a
// compare state for the registered id read.
// Reset clears the owner, both pointers and all slot valid bits at once; no sweep is needed.
// A new word is taken only when idle and the result register is free or being emptied.
module mutex_with_fifo_wait_queue #(
    parameter int unsigned MAX_PROCESSES = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // process_id[3:0], zero pad [7:4]
    input  logic [1:0] s_tuser,   // operation[1:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // status[2:0], wake_id[6:3], zero pad [7]
    output logic       m_tuser    // wake_valid
);

    localparam int unsigned IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCESSES - 1);

    mwq_pkg::state_t state_reg, state_next;

    logic                         owner_valid_reg, owner_valid_next;
    logic [MAX_PROCESSES-1:0]     ring_valid_reg, ring_valid_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [IDX_W-1:0]             tail_reg, tail_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;
    logic [mwq_pkg::PID_W-1:0]    pid_reg, pid_next;

    logic                         out_valid_reg, out_valid_next;
    logic [mwq_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic                         out_wake_valid_reg, out_wake_valid_next;
    logic [mwq_pkg::PID_W-1:0]    out_wake_id_reg, out_wake_id_next;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [IDX_W-1:0]             ram_raddr;
    logic [mwq_pkg::PID_W-1:0]    ram_rdata;

    logic                         accept;
    logic [1:0]                   in_op;
    logic [mwq_pkg::PID_W-1:0]    in_pid;
    logic [IDX_W-1:0]             head_adv;
    logic [IDX_W-1:0]             tail_adv;
    logic [IDX_W-1:0]             idx_inc;

    // Ring index step with wrap at the last slot.
    function automatic logic [IDX_W-1:0] ring_adv(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == LAST_IDX)
        begin
            res = '0;
        end
        else
        begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

    // Handshake and input unpacking.
    assign s_tready = (state_reg == mwq_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign in_op    = s_tuser;
    assign in_pid   = s_tdata[mwq_pkg::PID_W-1:0];
    assign head_adv = ring_adv(head_reg);
    assign tail_adv = ring_adv(tail_reg);
    assign idx_inc  = idx_reg + IDX_W'(1);

    // Waiting ids live in RAM; the slot valid bits stay in flops.
    assign ram_we    = accept && (in_op == mwq_pkg::OP_LOCK) && owner_valid_reg
                       && (head_adv != tail_reg);
    assign ram_waddr = head_reg;
    assign ram_raddr = (state_reg == mwq_pkg::ST_SKIP) ? tail_reg : idx_reg;

    mwq_ram #(
        .WIDTH (mwq_pkg::PID_W),
        .DEPTH (MAX_PROCESSES)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_pid),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwq_pkg::ST_IDLE:
            begin
                if (accept && (in_op == mwq_pkg::OP_UNLOCK))
                begin
                    state_next = mwq_pkg::ST_SKIP;
                end
                else if (accept && (in_op == mwq_pkg::OP_CANCEL))
                begin
                    state_next = mwq_pkg::ST_CSCAN;
                end
            end
            mwq_pkg::ST_SKIP:
            begin
                if (tail_reg == head_reg)
                begin
                    state_next = mwq_pkg::ST_IDLE;
                end
                else if (ring_valid_reg[tail_reg])
                begin
                    state_next = mwq_pkg::ST_WAKE;
                end
            end
            mwq_pkg::ST_WAKE:
            begin
                state_next = mwq_pkg::ST_IDLE;
            end
            mwq_pkg::ST_CSCAN:
            begin
                if (ring_valid_reg[idx_reg])
                begin
                    state_next = mwq_pkg::ST_CCMP;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = mwq_pkg::ST_IDLE;
                end
            end
            mwq_pkg::ST_CCMP:
            begin
                if ((ram_rdata == pid_reg) || (idx_reg == LAST_IDX))
                begin
                    state_next = mwq_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = mwq_pkg::ST_CSCAN;
                end
            end
            default:
            begin
                state_next = mwq_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath updates and result word for each state.
    always_comb
    begin
        owner_valid_next    = owner_valid_reg;
        ring_valid_next     = ring_valid_reg;
        head_next           = head_reg;
        tail_next           = tail_reg;
        idx_next            = idx_reg;
        pid_next            = pid_reg;
        out_valid_next      = out_valid_reg && !m_tready;
        out_status_next     = out_status_reg;
        out_wake_valid_next = out_wake_valid_reg;
        out_wake_id_next    = out_wake_id_reg;
        case (state_reg)
            mwq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pid_next = in_pid;
                    idx_next = '0;
                    case (in_op)
                        mwq_pkg::OP_LOCK:
                        begin
                            out_valid_next      = 1'b1;
                            out_wake_valid_next = 1'b0;
                            out_wake_id_next    = '0;
                            if (!owner_valid_reg)
                            begin
                                owner_valid_next = 1'b1;
                                out_status_next  = mwq_pkg::STAT_GRANTED;
                            end
                            else if (head_adv == tail_reg)
                            begin
                                out_status_next = mwq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ring_valid_next[head_reg] = 1'b1;
                                head_next                 = head_adv;
                                out_status_next           = mwq_pkg::STAT_QUEUED;
                            end
                        end
                        mwq_pkg::OP_UNLOCK:
                        begin
                            owner_valid_next = 1'b0;
                        end
                        mwq_pkg::OP_CANCEL:
                        begin
                            out_status_next = mwq_pkg::STAT_NOTFOUND;
                        end
                        mwq_pkg::OP_REINIT:
                        begin
                            owner_valid_next    = 1'b0;
                            ring_valid_next     = '0;
                            head_next           = '0;
                            tail_next           = '0;
                            out_valid_next      = 1'b1;
                            out_status_next     = mwq_pkg::STAT_DONE;
                            out_wake_valid_next = 1'b0;
                            out_wake_id_next    = '0;
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !m_tready;
                        end
                    endcase
                end
            end
            mwq_pkg::ST_SKIP:
            begin
                // Walk past cancelled slots until a waiter or the head is reached.
                if (tail_reg == head_reg)
                begin
                    out_valid_next      = 1'b1;
                    out_status_next     = mwq_pkg::STAT_DONE;
                    out_wake_valid_next = 1'b0;
                    out_wake_id_next    = '0;
                end
                else if (!ring_valid_reg[tail_reg])
                begin
                    tail_next = tail_adv;
                end
            end
            mwq_pkg::ST_WAKE:
            begin
                // Pop the waiter whose id was read in the previous cycle.
                ring_valid_next[tail_reg] = 1'b0;
                tail_next                 = tail_adv;
                out_valid_next            = 1'b1;
                out_status_next           = mwq_pkg::STAT_DONE;
                out_wake_valid_next       = 1'b1;
                out_wake_id_next          = ram_rdata;
            end
            mwq_pkg::ST_CSCAN:
            begin
                if (!ring_valid_reg[idx_reg])
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        out_valid_next      = 1'b1;
                        out_status_next     = mwq_pkg::STAT_NOTFOUND;
                        out_wake_valid_next = 1'b0;
                        out_wake_id_next    = '0;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end
            mwq_pkg::ST_CCMP:
            begin
                // Compare the id read from a valid slot with the one being cancelled.
                if (ram_rdata == pid_reg)
                begin
                    ring_valid_next[idx_reg] = 1'b0;
                    out_valid_next           = 1'b1;
                    out_status_next          = mwq_pkg::STAT_DONE;
                    out_wake_valid_next      = 1'b0;
                    out_wake_id_next         = '0;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    out_valid_next      = 1'b1;
                    out_status_next     = mwq_pkg::STAT_NOTFOUND;
                    out_wake_valid_next = 1'b0;
                    out_wake_id_next    = '0;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mwq_pkg::ST_IDLE;
            owner_valid_reg <= 1'b0;
            ring_valid_reg  <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            owner_valid_reg <= owner_valid_next;
            ring_valid_reg  <= ring_valid_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg            <= idx_next;
        pid_reg            <= pid_next;
        out_status_reg     <= out_status_next;
        out_wake_valid_reg <= out_wake_valid_next;
        out_wake_id_reg    <= out_wake_id_next;
    end

    // Result word packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_wake_id_reg, out_status_reg};
    assign m_tuser  = out_wake_valid_reg;

    // A queued result means the ring holds at least one slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == mwq_pkg::STAT_QUEUED)) |-> (head_reg != tail_reg))
        else $error("queued result with an empty ring");

    // A wakeup only comes from an unlock, which reports done and frees the owner.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_wake_valid_reg)
            |-> ((out_status_reg == mwq_pkg::STAT_DONE) && !owner_valid_reg))
        else $error("wakeup without a completed unlock");

    // A grant leaves the mutex held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == mwq_pkg::STAT_GRANTED)) |-> owner_valid_reg)
        else $error("grant reported but no owner");

    // Leaving the wake state always loads a result word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mwq_pkg::ST_WAKE) |=> (out_valid_reg && out_wake_valid_reg))
        else $error("wakeup result lost");

    // The slot at the head pointer is never marked valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        !ring_valid_reg[head_reg])
        else $error("valid slot at the head pointer");

endmodule
